### rtl/core/ss_pkg.sv
`timescale 1ns / 1ps

package ss_pkg;

  localparam int VALUE_W           = 16;
  localparam int SQUARE_W          = 31;
  localparam int IN_DATA_W         = 16;
  localparam int OUT_DATA_W        = 32;
  localparam int MAX_COUNT_DEFAULT = 64;

  // controller -> datapath
  typedef struct packed {
    logic load_ready;  // input channel open, accepted elements stored until the store is full
    logic scan_start;  // rewind scan pointer to the current pass index
    logic scan_step;   // issue the next store read of the pass
    logic commit;      // swap into place, load output register, advance pass or end the set
  } ss_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;   // all reads of the pass returned, minimum is final
    logic out_free;    // output register can take a result this cycle
    logic final_pass;  // current pass emits the last result of the set
  } ss_status_t;

endpackage

### rtl/core/sorted_squares_core.sv
`timescale 1ns / 1ps

// Squares a stream of signed 16-bit elements and returns the squares of each
// set in ascending order once the set's final element arrives.
//
// Input channel (s_axis): one element per transaction, tlast marks the final
// element of a set. Elements stream in at one per cycle while the channel is
// open. Up to MAX_COUNT are kept per set; further ones are dropped and flag
// every result of that set. Output channel (m_axis): one square per
// transaction, tlast on the largest, tuser set when the set overflowed.
//
// Sorting is a selection pass over the square store (one RAM read port), one
// pass per result. For a set of n kept elements the pass that emits result k
// (0-based) reads the n-k entries from slot k upward and keeps the smallest;
// the commit loads it into the output register and writes slot k's entry back
// into the smallest's slot. The input channel is closed from the final element
// until the last result is committed to the output register.
// If the receiver stalls, the result waits in the output register and the
// next pass halts before its commit until the register frees up.
// Reset (rst, synchronous) empties the set and the output register; the store
// itself is not cleared.
module sorted_squares_core import ss_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [15:0] value
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [30:0] square, [31] zero
  output logic                  m_axis_tlast,
  output logic                  m_axis_tuser   // [0] overflow
);

  ss_cmd_t             cmd;
  ss_status_t          status;
  logic [SQUARE_W-1:0] square;

  ss_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_last (s_axis_tlast),
    .status  (status),
    .cmd     (cmd)
  );

  ss_datapath #(
    .MAX_COUNT(MAX_COUNT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_valid    (s_axis_tvalid),
    .in_value    (s_axis_tdata[VALUE_W-1:0]),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_square  (square),
    .out_last    (m_axis_tlast),
    .out_overflow(m_axis_tuser)
  );

  assign s_axis_tready = cmd.load_ready;
  assign m_axis_tdata  = {{(OUT_DATA_W - SQUARE_W){1'b0}}, square};

endmodule

### rtl/core/ss_ram.sv
`timescale 1ns / 1ps

module ss_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/ss_ctrl.sv
`timescale 1ns / 1ps

module ss_ctrl import ss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_last,
  input  ss_status_t status,
  output ss_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_LOAD: begin
        cmd.load_ready = 1'b1;
        if (in_valid && in_last) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.scan_start = 1'b1;
        state_next     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done && status.out_free) begin
          cmd.commit = 1'b1;
          state_next = status.final_pass ? ST_LOAD : ST_START;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

### rtl/core/ss_datapath.sv
`timescale 1ns / 1ps

module ss_datapath import ss_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ss_cmd_t              cmd,
  output ss_status_t           status,
  input  logic                 in_valid,
  input  logic [VALUE_W-1:0]   in_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SQUARE_W-1:0]  out_square,
  output logic                 out_last,
  output logic                 out_overflow
);

  localparam int ADDR_W = $clog2(MAX_COUNT);
  localparam int CNT_W  = $clog2(MAX_COUNT + 1);

  logic [CNT_W-1:0]    count;
  logic                dropped;
  logic [ADDR_W-1:0]   pass_idx;
  logic [CNT_W-1:0]    scan_addr;
  logic                rd_valid;
  logic [ADDR_W-1:0]   rd_idx;
  logic                have_min;
  logic [SQUARE_W-1:0] min_val;
  logic [ADDR_W-1:0]   min_idx;
  logic [SQUARE_W-1:0] first_val;

  logic signed [2*VALUE_W-1:0] product;
  logic [SQUARE_W-1:0]         sq;
  logic                        store_full;
  logic                        load;
  logic                        issue;
  logic                        ram_we;
  logic [ADDR_W-1:0]           ram_waddr;
  logic [SQUARE_W-1:0]         ram_wdata;
  logic [SQUARE_W-1:0]         ram_rdata;

  assign product    = $signed(in_value) * $signed(in_value);
  assign sq         = product[SQUARE_W-1:0];
  assign store_full = (count == CNT_W'(MAX_COUNT));
  assign load       = cmd.load_ready && in_valid;
  assign issue      = cmd.scan_step && (scan_addr != count);

  // the slot at pass_idx is never read again, so only the displaced entry is written back
  assign ram_we    = (load && !store_full) || cmd.commit;
  assign ram_waddr = cmd.commit ? min_idx : count[ADDR_W-1:0];
  assign ram_wdata = cmd.commit ? first_val : sq;

  ss_ram #(
    .WIDTH(SQUARE_W),
    .DEPTH(MAX_COUNT)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_addr[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  assign status.scan_done  = (scan_addr == count) && !rd_valid;
  assign status.out_free   = !out_valid || out_ready;
  assign status.final_pass = ((CNT_W'(pass_idx) + CNT_W'(1)) == count);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      dropped   <= 1'b0;
      pass_idx  <= '0;
      scan_addr <= '0;
      rd_valid  <= 1'b0;
      have_min  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        if (store_full) begin
          dropped <= 1'b1;
        end else begin
          count <= count + CNT_W'(1);
        end
      end

      rd_valid <= issue;
      if (cmd.scan_start) begin
        scan_addr <= CNT_W'(pass_idx);
        have_min  <= 1'b0;
      end else if (issue) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end

      if (rd_valid) begin
        have_min <= 1'b1;
      end

      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (status.final_pass) begin
          count    <= '0;
          dropped  <= 1'b0;
          pass_idx <= '0;
        end else begin
          pass_idx <= pass_idx + ADDR_W'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx <= scan_addr[ADDR_W-1:0];
    end
    if (rd_valid) begin
      if (!have_min) begin
        first_val <= ram_rdata;
      end
      if (!have_min || (ram_rdata < min_val)) begin
        min_val <= ram_rdata;
        min_idx <= rd_idx;
      end
    end
    if (cmd.commit) begin
      out_square   <= min_val;
      out_last     <= status.final_pass;
      out_overflow <= dropped;
    end
  end

endmodule

### dv/sorted_squares_checker.sv
`timescale 1ns / 1ps

module sorted_squares_checker import ss_pkg::*; #(
  parameter int MAX_COUNT = MAX_COUNT_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  input  logic                  s_ready,
  input  logic [IN_DATA_W-1:0]  s_data,
  input  logic                  s_last,
  input  logic                  m_valid,
  input  logic                  m_ready,
  input  logic [OUT_DATA_W-1:0] m_data,
  input  logic                  m_last,
  input  logic                  m_user,
  output int                    errors,
  output int                    outstanding
);

  typedef struct packed {
    logic [SQUARE_W-1:0] square;
    logic                last;
    logic                overflow;
  } sq_result_t;

  logic [SQUARE_W-1:0] square_mem [MAX_COUNT];
  int                  kept;
  logic                dropped;
  sq_result_t          sorted_due [$];
  int                  err_count;

  function automatic logic [SQUARE_W-1:0] square_of_value(input logic [VALUE_W-1:0] v);
    logic signed [31:0] wide;
    logic signed [31:0] prod;
    wide = {{(32-VALUE_W){v[VALUE_W-1]}}, v};
    prod = wide * wide;
    return prod[SQUARE_W-1:0];
  endfunction

  // store the square unless the set is full; on the final element sort the set and queue its results
  task automatic absorb_element(input logic [VALUE_W-1:0] v, input logic is_last);
    logic [SQUARE_W-1:0] key;
    int                  j;
    sq_result_t          item;
    if (kept < MAX_COUNT) begin
      square_mem[kept] = square_of_value(v);
      kept++;
    end else begin
      dropped = 1'b1;
    end
    if (is_last) begin
      for (int i = 1; i < kept; i++) begin
        key = square_mem[i];
        j = i;
        while (j > 0 && square_mem[j-1] > key) begin
          square_mem[j] = square_mem[j-1];
          j--;
        end
        square_mem[j] = key;
      end
      for (int k = 0; k < kept; k++) begin
        item = '{square_mem[k], (k == kept - 1), dropped};
        sorted_due.insert(sorted_due.size(), item);
      end
      kept = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic check_result();
    sq_result_t want;
    if (sorted_due.size() == 0) begin
      err_count++;
      $display("%0t: unexpected result: tdata %0d tlast %b tuser %b",
               $time, m_data, m_last, m_user);
    end else begin
      want = sorted_due.pop_front();
      if (m_data !== {1'b0, want.square}) begin
        err_count++;
        $display("%0t: square mismatch: expected %0d, actual %0d",
                 $time, {1'b0, want.square}, m_data);
      end
      if (m_last !== want.last) begin
        err_count++;
        $display("%0t: tlast mismatch: expected %b, actual %b", $time, want.last, m_last);
      end
      if (m_user !== want.overflow) begin
        err_count++;
        $display("%0t: overflow mismatch: expected %b, actual %b",
                 $time, want.overflow, m_user);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      kept = 0;
      dropped = 1'b0;
      sorted_due.delete();
    end else begin
      // output first: a same-edge input only appends behind it
      if (m_valid && m_ready) check_result();
      if (s_valid && s_ready) absorb_element(s_data[VALUE_W-1:0], s_last);
    end
    errors      <= err_count;
    outstanding <= sorted_due.size();
  end

endmodule

### dv/sorted_squares_core_tb.sv
`timescale 1ns / 1ps

module sorted_squares_core_tb;
  import ss_pkg::*;

  localparam int MAX_COUNT    = MAX_COUNT_DEFAULT;
  localparam int RANDOM_ITEMS = 250;
  localparam int STALL_LIMIT  = 4000;
  localparam int LONG_HOLD    = 500;
  localparam int DRAIN_CYCLES = 100;
  localparam int DIRECTED_N   = 22;
  localparam int DIRECTED_SETS = 6;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  int mismatches;
  int outstanding;
  int idle_cycles;
  bit pressure_armed;

  // extremes, equal squares, sorted and reversed input, alternating bits
  logic [VALUE_W-1:0] directed_values [DIRECTED_N] = '{
    16'h8000,
    16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF,
    16'hFFFB, 16'h0005, 16'h0003, 16'hFFFD, 16'h0005,
    16'h0000, 16'h0001, 16'h0002, 16'h0003,
    16'h0007, 16'hFFFA, 16'h0005, 16'hFFFC,
    16'h5555, 16'hAAAA, 16'h8001
  };
  int directed_lens [DIRECTED_SETS] = '{1, 5, 5, 4, 4, 3};

  sorted_squares_core #(.MAX_COUNT(MAX_COUNT)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  sorted_squares_checker #(.MAX_COUNT(MAX_COUNT)) checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_data     (s_axis_tdata),
    .s_last     (s_axis_tlast),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_data     (m_axis_tdata),
    .m_last     (m_axis_tlast),
    .m_user     (m_axis_tuser),
    .errors     (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [VALUE_W-1:0] random_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return VALUE_W'($urandom());
    if (r < 7) return VALUE_W'($urandom_range(0, 16) - 8);  // small range, many equal squares
    if (r < 8) begin
      case ($urandom_range(0, 3))
        0:       return 16'h8000;
        1:       return 16'h7FFF;
        2:       return 16'h8001;
        default: return 16'h0000;
      endcase
    end
    return VALUE_W'($urandom_range(0, 2047) - 1024);
  endfunction

  function automatic int random_set_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(30, MAX_COUNT - 1);
  endfunction

  task automatic send_element(input logic [VALUE_W-1:0] value, input logic is_last,
                              input bit no_gaps);
    int gap;
    gap = no_gaps ? 0 : idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin : element_source
    int  idx;
    int  sets;
    int  sent;
    int  size;
    bit  burst;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    pressure_armed = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    idx = 0;
    for (int s = 0; s < DIRECTED_SETS; s++) begin
      for (int i = 0; i < directed_lens[s]; i++) begin
        send_element(directed_values[idx], i == directed_lens[s] - 1, s[0]);
        idx++;
      end
    end

    // receiver stalls on the next result while sets keep coming
    pressure_armed = 1'b1;
    sent = 0;
    sets = 0;
    while (sent < RANDOM_ITEMS || sets < 10) begin
      case (sets)
        2:       size = MAX_COUNT;
        5:       size = MAX_COUNT + 1;  // final element itself gets dropped
        9:       size = MAX_COUNT + 3 + $urandom_range(0, 4);
        default: size = random_set_size();
      endcase
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < size; i++)
        send_element(random_value(), i == size - 1, burst);
      sent += size;
      sets++;
    end
    s_axis_tvalid <= 1'b0;

    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS sorted_squares_core");
    else
      $display("FAIL sorted_squares_core");
    $finish;
  end

  initial begin : result_sink
    int gap;
    int served;
    bit steady;
    bit pressure_done;
    m_axis_tready = 1'b0;
    served = 0;
    steady = 1'b0;
    pressure_done = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (served % 16 == 0) steady = ($urandom_range(0, 3) == 0);
      if (pressure_armed && !pressure_done) begin
        m_axis_tready <= 1'b0;
        do @(posedge clk); while (!m_axis_tvalid);
        repeat (LONG_HOLD) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        gap = steady ? 0 : idle_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      served++;
    end
  end

  // cycles without any transaction on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL sorted_squares_core");
      $finish;
    end
  end

endmodule

### sim.f
rtl/core/ss_pkg.sv
rtl/core/ss_ram.sv
rtl/core/ss_ctrl.sv
rtl/core/ss_datapath.sv
rtl/core/sorted_squares_core.sv
dv/sorted_squares_checker.sv
dv/sorted_squares_core_tb.sv
